// ===== rtl/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial add unit.
// Holds the request and result structs, the term type and the cell operation codes.
// No dependencies.
package spa_pkg;

	// Default number of terms each polynomial store can hold.
	localparam int unsigned MAX_TERMS_DEF = 16;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_TERM_A = 2'd0;
	localparam logic [1:0] REQ_TERM_B = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	// One request item.
	typedef struct packed {
		logic [1:0]          req_type;
		logic signed [15:0]  term_coeff;
		logic [15:0]         term_power;
	} req_t;

	// One result item.
	typedef struct packed {
		logic signed [16:0]  sum_coeff;
		logic [15:0]         sum_power;
		logic                last_term;
		logic                empty_sum;
		logic                terms_dropped;
	} rsp_t;

	// One stored polynomial term.
	typedef struct packed {
		logic signed [15:0]  coeff;
		logic [15:0]         power;
	} term_t;

	// What every cell of a chain does in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

endpackage

// ===== rtl/sparse_polynomial_add_unit.sv =====
// Sparse polynomial add unit: two sorted term chains and the merge control.
// Depends on spa_pkg and instantiates spa_chain.
//
// Terms of polynomials A and B load one per cycle while no merge runs; each
// load drops into its place in a row of cells that keeps the polynomial
// sorted by descending power, and a term for a full store is dropped and
// flagged. A finish item merges the two chain heads one sum term per cycle
// while the result side does not stall, shifting the chains toward the head
// as terms are used; a finish gives one result per power step of the merge,
// at least one and at most 2*MAX_TERMS. Requests are stalled from the cycle
// after a finish is taken until its last result has moved into the output
// register; loads are taken while that result still waits.
module sparse_polynomial_add_unit #(
	parameter int unsigned MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spa_pkg::rsp_t rsp
);

	localparam int unsigned CW = $clog2(MAX_TERMS + 1);

	logic              busy_q;
	logic              overflow_q;
	logic [CW-1:0]     count_a_q;
	logic [CW-1:0]     count_b_q;
	logic              rsp_valid_q;
	spa_pkg::rsp_t     rsp_q;

	spa_pkg::cell_op_t op_a;
	spa_pkg::cell_op_t op_b;
	spa_pkg::term_t    ins;
	spa_pkg::term_t    head_a;
	spa_pkg::term_t    head_b;

	logic              req_xfer;
	logic              load_a;
	logic              load_b;
	logic              full_a;
	logic              full_b;
	logic              emit_go;
	logic              has_a;
	logic              has_b;
	logic              take_a;
	logic              take_b;
	logic [CW-1:0]     next_a;
	logic [CW-1:0]     next_b;
	logic              emit_last;
	logic              emit_empty;
	logic signed [16:0] emit_coeff;
	logic [15:0]       emit_power;

	// Request side: one transfer per cycle unless a merge is running.
	assign req_stall = busy_q;
	assign req_xfer  = req_valid && !busy_q;
	assign full_a    = (count_a_q == CW'(MAX_TERMS));
	assign full_b    = (count_b_q == CW'(MAX_TERMS));
	assign load_a    = req_xfer && (req.req_type == spa_pkg::REQ_TERM_A);
	assign load_b    = req_xfer && (req.req_type == spa_pkg::REQ_TERM_B);
	assign ins.coeff = req.term_coeff;
	assign ins.power = req.term_power;

	// Merge step: pick the higher head, or both when the powers match.
	assign emit_go    = busy_q && (!rsp_valid_q || !rsp_stall);
	assign has_a      = (count_a_q != '0);
	assign has_b      = (count_b_q != '0);
	assign take_a     = has_a && (!has_b || (head_a.power >= head_b.power));
	assign take_b     = has_b && (!has_a || (head_b.power >= head_a.power));
	assign emit_empty = !has_a && !has_b;
	assign next_a     = count_a_q - CW'(take_a);
	assign next_b     = count_b_q - CW'(take_b);
	assign emit_last  = (next_a == '0) && (next_b == '0);
	assign emit_coeff = (take_a ? 17'(head_a.coeff) : 17'sd0)
		+ (take_b ? 17'(head_b.coeff) : 17'sd0);
	assign emit_power = take_a ? head_a.power : (take_b ? head_b.power : 16'd0);

	// Chain operations: insert on a load with room, shift when the head is used.
	always_comb begin
		op_a = spa_pkg::CELL_HOLD;
		op_b = spa_pkg::CELL_HOLD;
		if (load_a && !full_a) begin
			op_a = spa_pkg::CELL_INSERT;
		end else if (emit_go && take_a) begin
			op_a = spa_pkg::CELL_SHIFT;
		end
		if (load_b && !full_b) begin
			op_b = spa_pkg::CELL_INSERT;
		end else if (emit_go && take_b) begin
			op_b = spa_pkg::CELL_SHIFT;
		end
	end

	spa_chain #(.MAX_TERMS(MAX_TERMS)) u_chain_a (
		.clk   (clk),
		.op    (op_a),
		.ins   (ins),
		.count (count_a_q),
		.head  (head_a)
	);

	spa_chain #(.MAX_TERMS(MAX_TERMS)) u_chain_b (
		.clk   (clk),
		.op    (op_b),
		.ins   (ins),
		.count (count_b_q),
		.head  (head_b)
	);

	// Counts, drop flag and merge state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			overflow_q <= 1'b0;
			count_a_q  <= '0;
			count_b_q  <= '0;
		end else if (emit_go) begin
			count_a_q <= next_a;
			count_b_q <= next_b;
			if (emit_last) begin
				busy_q     <= 1'b0;
				overflow_q <= 1'b0;
			end
		end else if (req_xfer) begin
			if (load_a) begin
				if (full_a) begin
					overflow_q <= 1'b1;
				end else begin
					count_a_q <= count_a_q + CW'(1);
				end
			end
			if (load_b) begin
				if (full_b) begin
					overflow_q <= 1'b1;
				end else begin
					count_b_q <= count_b_q + CW'(1);
				end
			end
			if (req.req_type == spa_pkg::REQ_FINISH) begin
				busy_q <= 1'b1;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_q.sum_coeff     <= emit_coeff;
			rsp_q.sum_power     <= emit_power;
			rsp_q.last_term     <= emit_last;
			rsp_q.empty_sum     <= emit_empty;
			rsp_q.terms_dropped <= overflow_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An empty sum is always the only, and so the last, result of its run.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.empty_sum || rsp.last_term))
		else $error("empty sum result not marked last");

	// A taken finish holds off further requests until the merge ends.
	a_finish_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.req_type == spa_pkg::REQ_FINISH) |=> req_stall)
		else $error("request not stalled after finish");

	// The last result of a merge ends the run and clears both stores.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && emit_last) |=> (!busy_q && count_a_q == '0 && count_b_q == '0))
		else $error("merge did not end after last result");

	// Neither store count ever passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= CW'(MAX_TERMS)) && (count_b_q <= CW'(MAX_TERMS)))
		else $error("store count beyond depth");

endmodule

// ===== rtl/spa_cell.sv =====
// One cell of a sorted term chain: holds a single term.
// Depends on spa_pkg for the term type and the cell operation codes.
module spa_cell (
	input  logic              clk,
	input  spa_pkg::cell_op_t op,
	input  spa_pkg::term_t    ins,
	input  spa_pkg::term_t    left,
	input  spa_pkg::term_t    right,
	input  logic              left_ge,
	input  logic              in_range,
	output spa_pkg::term_t    data,
	output logic              ge
);

	spa_pkg::term_t data_q;

	// The cell keeps its term on insert when it holds a power at least as high.
	assign ge   = in_range && (data_q.power >= ins.power);
	assign data = data_q;

	// Insert takes the new term at the boundary and the left term past it;
	// shift moves the chain one place toward the head.
	always_ff @(posedge clk) begin
		unique case (op)
			spa_pkg::CELL_HOLD: begin
				data_q <= data_q;
			end
			spa_pkg::CELL_INSERT: begin
				if (!ge) begin
					data_q <= left_ge ? ins : left;
				end
			end
			spa_pkg::CELL_SHIFT: begin
				data_q <= right;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

// ===== rtl/spa_chain.sv =====
// A row of term cells that keeps one polynomial sorted by descending power.
// Depends on spa_pkg and instantiates spa_cell.
module spa_chain #(
	parameter int unsigned MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
	localparam int unsigned CW = $clog2(MAX_TERMS + 1)
) (
	input  logic              clk,
	input  spa_pkg::cell_op_t op,
	input  spa_pkg::term_t    ins,
	input  logic [CW-1:0]     count,
	output spa_pkg::term_t    head
);

	spa_pkg::term_t cell_data [MAX_TERMS];
	logic           cell_ge   [MAX_TERMS];

	// Each cell sees the new term and both neighbors; the ends are tied off.
	for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
		spa_pkg::term_t left_data;
		spa_pkg::term_t right_data;
		logic           left_ge;

		if (i == 0) begin : g_first
			assign left_data = ins;
			assign left_ge   = 1'b1;
		end else begin : g_mid
			assign left_data = cell_data[i-1];
			assign left_ge   = cell_ge[i-1];
		end

		if (i == MAX_TERMS - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		spa_cell u_cell (
			.clk      (clk),
			.op       (op),
			.ins      (ins),
			.left     (left_data),
			.right    (right_data),
			.left_ge  (left_ge),
			.in_range (CW'(i) < count),
			.data     (cell_data[i]),
			.ge       (cell_ge[i])
		);
	end

	assign head = cell_data[0];

endmodule
